// File: rtl/qvr_pkg.sv
// Shared widths, types and constants of the quaternion vector rotate unit.
`timescale 1ns / 1ps

package qvr_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned PROD_W     = 2 * SAMPLE_W;
  localparam int unsigned COEF_W     = PROD_W + 2;
  localparam int unsigned TERM_W     = COEF_W + SAMPLE_W;
  localparam int unsigned SUM_W      = TERM_W + 1;
  localparam int unsigned FRAC_BITS  = 28;
  localparam int unsigned RND_W      = SUM_W - FRAC_BITS;
  localparam int unsigned NUM_STAGES = 5;
  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned NUM_COEFS  = NUM_AXES * NUM_AXES;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [TERM_W-1:0]   term_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [RND_W-1:0]    rnd_t;

  localparam sum_t    ROUND_HALF = SUM_W'(64'd1 << (FRAC_BITS - 1));
  localparam sample_t SAMPLE_MAX = SAMPLE_W'(32767);
  localparam sample_t SAMPLE_MIN = SAMPLE_W'(-32768);
  localparam rnd_t    RND_MAX    = RND_W'(32767);
  localparam rnd_t    RND_MIN    = RND_W'(-32768);

endpackage

// File: rtl/quaternion_vector_rotate_unit.sv
// Top level: pipelined quaternion rotation of a body-frame vector into the inertial frame.
`timescale 1ns / 1ps

// Takes one transaction per clock cycle while in_stall is low, and returns the results in
// the order they were accepted. The five register stages are: quaternion
// products, direction-cosine coefficients, coefficient-by-sample products, rounded row
// sums, and saturated outputs. Each stage holds while the one after it is full and
// stalled, so empty stages keep absorbing transactions while a result waits; in_stall
// rises only when all five stages are occupied and out_stall is high. Arithmetic is
// exact up to one round-to-nearest (ties upward) of each row sum, followed by
// saturation to signed 16 bits; out_clipped flags any saturated component.
module quaternion_vector_rotate_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  qvr_pkg::sample_t in_quat_w,
  input  qvr_pkg::sample_t in_quat_x,
  input  qvr_pkg::sample_t in_quat_y,
  input  qvr_pkg::sample_t in_quat_z,
  input  qvr_pkg::sample_t in_body_x,
  input  qvr_pkg::sample_t in_body_y,
  input  qvr_pkg::sample_t in_body_z,
  output logic            out_valid,
  input  logic            out_stall,
  output qvr_pkg::sample_t out_inert_x,
  output qvr_pkg::sample_t out_inert_y,
  output qvr_pkg::sample_t out_inert_z,
  output logic            out_clipped
);
  import qvr_pkg::*;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] adv;

  prod_t   ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  sample_t b0_r [NUM_AXES];
  sample_t b1_r [NUM_AXES];
  coef_t   coef_r   [NUM_COEFS];
  coef_t   coef_nxt [NUM_COEFS];
  term_t   term_r   [NUM_COEFS];
  term_t   term_nxt [NUM_COEFS];
  rnd_t    rnd_r    [NUM_AXES];
  rnd_t    rnd_nxt  [NUM_AXES];
  sample_t inert_r   [NUM_AXES];
  sample_t inert_nxt [NUM_AXES];
  logic    clip_r;
  logic    clip_nxt;
  sum_t    row_sum;

  always_comb begin
    adv[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ww_r    <= in_quat_w * in_quat_w;
      xx_r    <= in_quat_x * in_quat_x;
      yy_r    <= in_quat_y * in_quat_y;
      zz_r    <= in_quat_z * in_quat_z;
      xy_r    <= in_quat_x * in_quat_y;
      xz_r    <= in_quat_x * in_quat_z;
      yz_r    <= in_quat_y * in_quat_z;
      wx_r    <= in_quat_w * in_quat_x;
      wy_r    <= in_quat_w * in_quat_y;
      wz_r    <= in_quat_w * in_quat_z;
      b0_r[0] <= in_body_x;
      b0_r[1] <= in_body_y;
      b0_r[2] <= in_body_z;
    end
  end

  always_comb begin
    coef_nxt[0] = COEF_W'(ww_r) + COEF_W'(xx_r) - COEF_W'(yy_r) - COEF_W'(zz_r);
    coef_nxt[1] = (COEF_W'(xy_r) - COEF_W'(wz_r)) <<< 1;
    coef_nxt[2] = (COEF_W'(xz_r) + COEF_W'(wy_r)) <<< 1;
    coef_nxt[3] = (COEF_W'(xy_r) + COEF_W'(wz_r)) <<< 1;
    coef_nxt[4] = COEF_W'(ww_r) - COEF_W'(xx_r) + COEF_W'(yy_r) - COEF_W'(zz_r);
    coef_nxt[5] = (COEF_W'(yz_r) - COEF_W'(wx_r)) <<< 1;
    coef_nxt[6] = (COEF_W'(xz_r) - COEF_W'(wy_r)) <<< 1;
    coef_nxt[7] = (COEF_W'(yz_r) + COEF_W'(wx_r)) <<< 1;
    coef_nxt[8] = COEF_W'(ww_r) - COEF_W'(xx_r) - COEF_W'(yy_r) + COEF_W'(zz_r);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      coef_r <= coef_nxt;
      b1_r   <= b0_r;
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        term_nxt[r*NUM_AXES+c] = TERM_W'(coef_r[r*NUM_AXES+c]) * TERM_W'(b1_r[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      term_r <= term_nxt;
    end
  end

  always_comb begin
    row_sum = '0;
    for (int r = 0; r < NUM_AXES; r++) begin
      row_sum = SUM_W'(term_r[r*NUM_AXES]) + SUM_W'(term_r[r*NUM_AXES+1])
              + SUM_W'(term_r[r*NUM_AXES+2]) + ROUND_HALF;
      rnd_nxt[r] = rnd_t'(row_sum[SUM_W-1:FRAC_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      rnd_r <= rnd_nxt;
    end
  end

  always_comb begin
    clip_nxt = 1'b0;
    for (int r = 0; r < NUM_AXES; r++) begin
      if (rnd_r[r] > RND_MAX) begin
        inert_nxt[r] = SAMPLE_MAX;
        clip_nxt     = 1'b1;
      end else if (rnd_r[r] < RND_MIN) begin
        inert_nxt[r] = SAMPLE_MIN;
        clip_nxt     = 1'b1;
      end else begin
        inert_nxt[r] = rnd_r[r][SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      inert_r <= inert_nxt;
      clip_r  <= clip_nxt;
    end
  end

  assign in_stall    = !adv[0];
  assign out_valid   = vld_r[NUM_STAGES-1];
  assign out_inert_x = inert_r[0];
  assign out_inert_y = inert_r[1];
  assign out_inert_z = inert_r[2];
  assign out_clipped = clip_r;

endmodule

// File: rtl/qvr_checker.sv
// Port-level checker for the quaternion vector rotate unit, with its bind statement.
`timescale 1ns / 1ps

module qvr_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input qvr_pkg::sample_t in_quat_w,
  input qvr_pkg::sample_t in_quat_x,
  input qvr_pkg::sample_t in_quat_y,
  input qvr_pkg::sample_t in_quat_z,
  input qvr_pkg::sample_t in_body_x,
  input qvr_pkg::sample_t in_body_y,
  input qvr_pkg::sample_t in_body_z,
  input logic             out_valid,
  input logic             out_stall,
  input qvr_pkg::sample_t out_inert_x,
  input qvr_pkg::sample_t out_inert_y,
  input qvr_pkg::sample_t out_inert_z,
  input logic             out_clipped
);
  import qvr_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_quat_w) && $stable(in_quat_x)
                             && $stable(in_quat_y) && $stable(in_quat_z)
                             && $stable(in_body_x) && $stable(in_body_y)
                             && $stable(in_body_z))
    else $error("stalled input transaction changed");

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_inert_x) && $stable(out_inert_y)
                               && $stable(out_inert_z) && $stable(out_clipped))
    else $error("stalled result changed");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output side can drain");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      out_inert_x == SAMPLE_MAX || out_inert_x == SAMPLE_MIN ||
      out_inert_y == SAMPLE_MAX || out_inert_y == SAMPLE_MIN ||
      out_inert_z == SAMPLE_MAX || out_inert_z == SAMPLE_MIN)
    else $error("clip flag set with no component at a limit");

endmodule

bind quaternion_vector_rotate_unit qvr_checker u_qvr_checker (.*);

// File: sim/quaternion_vector_rotate_unit_tb.sv
// Self-checking testbench for the quaternion vector rotate unit.
`timescale 1ns / 1ps

module quaternion_vector_rotate_unit_tb;
  import qvr_pkg::*;

  typedef struct {
    sample_t quat_w;
    sample_t quat_x;
    sample_t quat_y;
    sample_t quat_z;
    sample_t body_x;
    sample_t body_y;
    sample_t body_z;
  } attitude_sample_t;

  typedef struct {
    sample_t inert_x;
    sample_t inert_y;
    sample_t inert_z;
    logic    clipped;
  } inertial_vector_t;

  localparam longint HALF_LSB = longint'(1) << (FRAC_BITS - 1);
  localparam int unsigned MAX_PRINTED = 100;

  logic    clk = 1'b0;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  sample_t in_quat_w;
  sample_t in_quat_x;
  sample_t in_quat_y;
  sample_t in_quat_z;
  sample_t in_body_x;
  sample_t in_body_y;
  sample_t in_body_z;
  logic    out_valid;
  logic    out_stall;
  sample_t out_inert_x;
  sample_t out_inert_y;
  sample_t out_inert_z;
  logic    out_clipped;

  inertial_vector_t expected_inertial[$];
  int unsigned      mismatch_count = 0;
  bit               steady = 1'b0;

  quaternion_vector_rotate_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_quat_w   (in_quat_w),
    .in_quat_x   (in_quat_x),
    .in_quat_y   (in_quat_y),
    .in_quat_z   (in_quat_z),
    .in_body_x   (in_body_x),
    .in_body_y   (in_body_y),
    .in_body_z   (in_body_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_inert_x (out_inert_x),
    .out_inert_y (out_inert_y),
    .out_inert_z (out_inert_z),
    .out_clipped (out_clipped)
  );

  always #5 clk = ~clk;

  function automatic inertial_vector_t rotate_to_inertial(input attitude_sample_t a);
    longint w, x, y, z;
    longint body [3];
    longint dcm [9];
    longint row_sum;
    longint rounded;
    sample_t axis_out [3];
    inertial_vector_t v;
    w = a.quat_w;
    x = a.quat_x;
    y = a.quat_y;
    z = a.quat_z;
    body[0] = a.body_x;
    body[1] = a.body_y;
    body[2] = a.body_z;
    dcm[0] = w * w + x * x - y * y - z * z;
    dcm[1] = 2 * (x * y - w * z);
    dcm[2] = 2 * (x * z + w * y);
    dcm[3] = 2 * (x * y + w * z);
    dcm[4] = w * w - x * x + y * y - z * z;
    dcm[5] = 2 * (y * z - w * x);
    dcm[6] = 2 * (x * z - w * y);
    dcm[7] = 2 * (y * z + w * x);
    dcm[8] = w * w - x * x - y * y + z * z;
    v.clipped = 1'b0;
    for (int r = 0; r < 3; r++) begin
      row_sum = dcm[3*r] * body[0] + dcm[3*r+1] * body[1] + dcm[3*r+2] * body[2];
      rounded = (row_sum + HALF_LSB) >>> FRAC_BITS;
      if (rounded > 32767) begin
        rounded = 32767;
        v.clipped = 1'b1;
      end else if (rounded < -32768) begin
        rounded = -32768;
        v.clipped = 1'b1;
      end
      axis_out[r] = sample_t'(rounded);
    end
    v.inert_x = axis_out[0];
    v.inert_y = axis_out[1];
    v.inert_z = axis_out[2];
    return v;
  endfunction

  function automatic attitude_sample_t make_attitude(input int w, input int x, input int y,
                                                     input int z, input int bx, input int by,
                                                     input int bz);
    attitude_sample_t a;
    a.quat_w = sample_t'(w);
    a.quat_x = sample_t'(x);
    a.quat_y = sample_t'(y);
    a.quat_z = sample_t'(z);
    a.body_x = sample_t'(bx);
    a.body_y = sample_t'(by);
    a.body_z = sample_t'(bz);
    return a;
  endfunction

  function automatic attitude_sample_t random_attitude_sample();
    real qw, qx, qy, qz, norm, gain;
    attitude_sample_t a;
    qw = real'(int'($urandom_range(0, 65535)) - 32768);
    qx = real'(int'($urandom_range(0, 65535)) - 32768);
    qy = real'(int'($urandom_range(0, 65535)) - 32768);
    qz = real'(int'($urandom_range(0, 65535)) - 32768);
    norm = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
    if (norm < 1.0) norm = 1.0;
    if ($urandom_range(0, 7) == 0)
      gain = 16384.0 * (0.25 + 1.74 * $urandom_range(0, 1000) / 1000.0);
    else
      gain = 16384.0;
    a.quat_w = sample_t'($rtoi(qw * gain / norm));
    a.quat_x = sample_t'($rtoi(qx * gain / norm));
    a.quat_y = sample_t'($rtoi(qy * gain / norm));
    a.quat_z = sample_t'($rtoi(qz * gain / norm));
    if ($urandom_range(0, 3) == 0) begin
      a.body_x = sample_t'(int'($urandom_range(0, 2000)) - 1000);
      a.body_y = sample_t'(int'($urandom_range(0, 2000)) - 1000);
      a.body_z = sample_t'(int'($urandom_range(0, 2000)) - 1000);
    end else begin
      a.body_x = sample_t'($urandom);
      a.body_y = sample_t'($urandom);
      a.body_z = sample_t'($urandom);
    end
    return a;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < MAX_PRINTED)
      $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_transaction(input attitude_sample_t a);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_quat_w <= a.quat_w;
    in_quat_x <= a.quat_x;
    in_quat_y <= a.quat_y;
    in_quat_z <= a.quat_z;
    in_body_x <= a.body_x;
    in_body_y <= a.body_y;
    in_body_z <= a.body_z;
    do @(posedge clk); while (in_stall);
    expected_inertial.push_back(rotate_to_inertial(a));
  endtask

  task automatic test_identity_attitude();
    send_transaction(make_attitude(16384, 0, 0, 0, 0, 0, 0));
    send_transaction(make_attitude(16384, 0, 0, 0, 32767, -32768, 1));
    send_transaction(make_attitude(16384, 0, 0, 0, -1, 12345, -32768));
  endtask

  task automatic test_quarter_turns();
    send_transaction(make_attitude(11585, 11585, 0, 0, 1000, 2000, 3000));
    send_transaction(make_attitude(11585, 0, 11585, 0, 1000, 2000, 3000));
    send_transaction(make_attitude(11585, 0, 0, 11585, 1000, 2000, 3000));
    send_transaction(make_attitude(0, 16384, 0, 0, 32767, 32767, -32768));
  endtask

  task automatic test_rounding_ties();
    send_transaction(make_attitude(8192, 0, 0, 0, 2, -2, 6));
    send_transaction(make_attitude(8192, 0, 0, 0, -6, 0, 0));
  endtask

  task automatic test_extreme_fields();
    send_transaction(make_attitude(-32768, -32768, -32768, -32768, 32767, 32767, 32767));
    send_transaction(make_attitude(32767, 32767, 32767, 32767, -32768, -32768, -32768));
    send_transaction(make_attitude(0, 0, 0, 0, 32767, -32768, 32767));
    send_transaction(make_attitude(32767, -32768, 32767, -32768, -32768, 32767, -32768));
    send_transaction(make_attitude(32767, 0, 0, 0, 10000, -10000, 5000));
  endtask

  task automatic test_random_attitudes(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      send_transaction(random_attitude_sample());
    end
    steady = 1'b0;
  endtask

  task automatic test_random_bit_patterns(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      send_transaction(make_attitude($urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom));
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    inertial_vector_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_inertial.size() == 0) begin
        report_mismatch("result with no transaction pending, inert_x", out_inert_x, 0);
      end else begin
        want = expected_inertial.pop_front();
        if (out_inert_x !== want.inert_x) report_mismatch("inert_x", out_inert_x, want.inert_x);
        if (out_inert_y !== want.inert_y) report_mismatch("inert_y", out_inert_y, want.inert_y);
        if (out_inert_z !== want.inert_z) report_mismatch("inert_z", out_inert_z, want.inert_z);
        if (out_clipped !== want.clipped) report_mismatch("clipped", out_clipped, want.clipped);
      end
    end
  end

  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 19);
      if (hold != 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #2_000_000;
    $display("quaternion_vector_rotate_unit verification failed");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_quat_w = '0;
    in_quat_x = '0;
    in_quat_y = '0;
    in_quat_z = '0;
    in_body_x = '0;
    in_body_y = '0;
    in_body_z = '0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_identity_attitude();
    test_quarter_turns();
    test_rounding_ties();
    test_extreme_fields();
    test_random_attitudes(420);
    test_random_bit_patterns(220);

    @(negedge clk) in_valid <= 1'b0;
    while (expected_inertial.size() != 0) @(posedge clk);
    repeat (2 * NUM_STAGES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("quaternion_vector_rotate_unit verification clean");
    end else begin
      $display("quaternion_vector_rotate_unit verification failed");
    end
    $finish;
  end

endmodule
